[hdl/itf_pkg.sv]
package itf_pkg;

	localparam int CNT_W = 7;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [3:0] DEC_BASE   = 4'd10;

	localparam logic [1:0] RADIX_OCT = 2'd0;
	localparam logic [1:0] RADIX_DEC = 2'd1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CONV  = 9'b000000010,
		S_TRIM  = 9'b000000100,
		S_SIZE  = 9'b000001000,
		S_LEAD  = 9'b000010000,
		S_SIGN  = 9'b000100000,
		S_ZERO  = 9'b001000000,
		S_DIGIT = 9'b010000000,
		S_TRAIL = 9'b100000000
	} state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base_ch;
		base_ch = upper ? CH_UPPER_A : CH_LOWER_A;
		if (d < DEC_BASE) begin
			return CH_ZERO + {4'b0000, d};
		end else begin
			return base_ch + {4'b0000, d} - {4'b0000, DEC_BASE};
		end
	endfunction

endpackage

[hdl/integer_to_text_formatter_core.sv]
// Formats one integer per input word into ASCII text, one character per output word, with
// last_char set on the final character. An accepted word is first turned into digits: octal
// and hex digits are taken straight from the magnitude, decimal goes through a shift-and-add-3
// converter that works through all VALUE_BITS bits of the magnitude. Leading zero digits are
// then dropped one per cycle (up to (VALUE_BITS+2)/3 - 1 of them), a sizing state works out
// the padding, and the text leaves at one character per cycle while the consumer keeps up. A
// new word is taken only once the previous text has been fully handed to the output register.
module integer_to_text_formatter_core #(
	parameter int VALUE_BITS = 64,
	parameter int MAX_CHARS  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [63:0] value,
	input  logic              signed_mode,
	input  logic [1:0]        radix_select,
	input  logic              upper_hex,
	input  logic [6:0]        field_width,
	input  logic signed [6:0] min_digits,
	input  logic              pad_right,
	input  logic              zero_fill,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        char_code,
	output logic              last_char
);

	import itf_pkg::*;

	localparam int NDIG = (VALUE_BITS + 2) / 3;
	localparam int DW   = 4 * NDIG;
	localparam int NDW  = $clog2(NDIG + 1);
	localparam int CW   = $clog2(VALUE_BITS + 1);

	state_t                state_q;
	logic [DW-1:0]         digits_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [CW-1:0]         cnt_q;
	logic [NDW-1:0]        nd_q;
	logic                  neg_q;
	logic                  upper_q;
	logic                  left_q;
	logic                  zpad_q;
	logic [CNT_W-1:0]      width_q;
	logic [CNT_W-1:0]      prec_q;
	logic [CNT_W-1:0]      lead_q;
	logic [CNT_W-1:0]      zero_q;
	logic [CNT_W-1:0]      trail_q;
	logic [CNT_W-1:0]      rem_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic [VALUE_BITS-1:0] v_in;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic [3*NDIG-1:0]     mag_ext;
	logic [DW-1:0]         oct_load;
	logic [DW-1:0]         hex_load;
	logic [DW-1:0]         adj;
	logic [CNT_W-1:0]      width_in;
	logic [CNT_W-1:0]      prec_in;
	logic [CNT_W-1:0]      nd_ext;
	logic [CNT_W-1:0]      prec_extra;
	logic [CNT_W-1:0]      len;
	logic [CNT_W-1:0]      pad;
	logic [CNT_W-1:0]      lead_n;
	logic [CNT_W-1:0]      zero_n;
	logic [CNT_W-1:0]      trail_n;
	state_t                size_next;
	logic [3:0]            top_digit;
	logic                  accept;
	logic                  produce;
	logic                  emitting;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;
	assign top_digit = digits_q[DW-1 -: 4];

	assign emitting = (state_q == S_LEAD) || (state_q == S_SIGN) || (state_q == S_ZERO) ||
		(state_q == S_DIGIT) || (state_q == S_TRAIL);
	assign produce  = emitting && (!out_valid_q || out_ready);

	always_comb begin
		v_in    = value[VALUE_BITS-1:0];
		neg_in  = signed_mode && v_in[VALUE_BITS-1];
		mag_in  = neg_in ? (~v_in + 1'b1) : v_in;
		mag_ext = (3*NDIG)'(mag_in);
		hex_load = DW'(mag_in);
		for (int i = 0; i < NDIG; i++) begin
			oct_load[4*i +: 4] = {1'b0, mag_ext[3*i +: 3]};
		end
		for (int i = 0; i < NDIG; i++) begin
			adj[4*i +: 4] = (digits_q[4*i +: 4] >= 4'd5) ? digits_q[4*i +: 4] + 4'd3
				: digits_q[4*i +: 4];
		end
		width_in = (field_width > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : field_width;
		if (min_digits[6]) begin
			prec_in = '0;
		end else if ($unsigned(min_digits) > CNT_W'(MAX_CHARS - 1)) begin
			prec_in = CNT_W'(MAX_CHARS - 1);
		end else begin
			prec_in = $unsigned(min_digits);
		end
	end

	always_comb begin
		nd_ext     = CNT_W'(nd_q);
		prec_extra = (prec_q > nd_ext) ? prec_q - nd_ext : '0;
		len        = nd_ext + prec_extra + CNT_W'(neg_q);
		pad        = (width_q > len) ? width_q - len : '0;
		lead_n     = (!left_q && !zpad_q) ? pad : '0;
		zero_n     = prec_extra + ((!left_q && zpad_q) ? pad : '0);
		trail_n    = left_q ? pad : '0;
		priority if (lead_n != '0) begin
			size_next = S_LEAD;
		end else if (neg_q) begin
			size_next = S_SIGN;
		end else if (zero_n != '0) begin
			size_next = S_ZERO;
		end else begin
			size_next = S_DIGIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (radix_select == RADIX_DEC) ? S_CONV : S_TRIM;
					end
				end
				S_CONV: begin
					if (cnt_q == CW'(1)) begin
						state_q <= S_TRIM;
					end
				end
				S_TRIM: begin
					if (!(top_digit == 4'd0 && nd_q > NDW'(1))) begin
						state_q <= S_SIZE;
					end
				end
				S_SIZE: begin
					state_q <= size_next;
				end
				S_LEAD: begin
					if (produce && lead_q == CNT_W'(1)) begin
						state_q <= neg_q ? S_SIGN : ((zero_q != '0) ? S_ZERO : S_DIGIT);
					end
				end
				S_SIGN: begin
					if (produce) begin
						state_q <= (zero_q != '0) ? S_ZERO : S_DIGIT;
					end
				end
				S_ZERO: begin
					if (produce && zero_q == CNT_W'(1)) begin
						state_q <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (produce && nd_q == NDW'(1)) begin
						state_q <= (trail_q != '0) ? S_TRAIL : S_IDLE;
					end
				end
				S_TRAIL: begin
					if (produce && trail_q == CNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			rem_q  <= rem_q - 1'b1;
			last_q <= (rem_q == CNT_W'(1));
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					neg_q   <= neg_in;
					upper_q <= upper_hex && radix_select[1];
					left_q  <= pad_right;
					zpad_q  <= zero_fill;
					width_q <= width_in;
					prec_q  <= prec_in;
					bin_q   <= mag_in;
					cnt_q   <= CW'(VALUE_BITS);
					nd_q    <= NDW'(NDIG);
					if (radix_select == RADIX_DEC) begin
						digits_q <= '0;
					end else if (radix_select == RADIX_OCT) begin
						digits_q <= oct_load;
					end else begin
						digits_q <= hex_load;
					end
				end
			end
			S_CONV: begin
				digits_q <= {adj[DW-2:0], bin_q[VALUE_BITS-1]};
				bin_q    <= bin_q << 1;
				cnt_q    <= cnt_q - 1'b1;
			end
			S_TRIM: begin
				if (top_digit == 4'd0 && nd_q > NDW'(1)) begin
					digits_q <= digits_q << 4;
					nd_q     <= nd_q - 1'b1;
				end
			end
			S_SIZE: begin
				lead_q  <= lead_n;
				zero_q  <= zero_n;
				trail_q <= trail_n;
				rem_q   <= len + pad;
			end
			S_LEAD: begin
				if (produce) begin
					char_q <= CH_SPACE;
					lead_q <= lead_q - 1'b1;
				end
			end
			S_SIGN: begin
				if (produce) begin
					char_q <= CH_MINUS;
				end
			end
			S_ZERO: begin
				if (produce) begin
					char_q <= CH_ZERO;
					zero_q <= zero_q - 1'b1;
				end
			end
			S_DIGIT: begin
				if (produce) begin
					char_q   <= digit_char(top_digit, upper_q);
					digits_q <= digits_q << 4;
					nd_q     <= nd_q - 1'b1;
				end
			end
			S_TRAIL: begin
				if (produce) begin
					char_q  <= CH_SPACE;
					trail_q <= trail_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && rem_q == CNT_W'(1)) |=> (state_q == S_IDLE))
		else $error("text ended with characters still counted or phases left");

	a_no_extra_char: assert property (@(posedge clk) disable iff (!arst_n)
		produce |-> (rem_q != '0))
		else $error("character produced beyond the computed text length");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGIT) |-> (nd_q != '0))
		else $error("digit phase entered with no digits left");

	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emitting && $past(state_q) == S_SIZE) |-> (rem_q != '0))
		else $error("sized text is empty");

endmodule
